// ===== hw/rtl/apu_pkg.sv =====
// Package with constants, types and state codes shared by the Adam parameter update block.
`default_nettype none
package apu_pkg;

    // Moment store geometry
    localparam int ELEMENT_COUNT = 4096;
    localparam int ADDR_W        = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;

    // Field widths
    localparam int IDX_W = 12;
    localparam int VAL_W = 32;
    localparam int LR_W  = 24;
    localparam int V_W   = 64;

    localparam logic [LR_W-1:0] LR_RESET = 24'd16777;

    // Moment blend weights in Q0.16; each pair sums to 65536
    localparam logic signed [49:0] B1_Q16  = 50'sd58982;
    localparam logic signed [49:0] B1C_Q16 = 50'sd6554;
    localparam logic [80:0]        B2_Q16  = 81'd64881;
    localparam logic [80:0]        B2C_Q16 = 81'd655;

    // Square root: one result bit per stage
    localparam int SQ_STEPS = V_W / 2;

    // Division: |lr*m| below 2^55, divisor (root+1)<<8 below 2^41, quotient below 2^48
    localparam int NUM_W     = 56;
    localparam int DEN_W     = 41;
    localparam int Q_W       = 48;
    localparam int DIV_STEPS = Q_W;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } apu_state_t;

    // Sideband carried through the square root pipeline
    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] cur;
        logic signed [VAL_W-1:0] m;
        logic                    in_range;
    } apu_tag_t;

    // Sideband carried through the divider pipeline
    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] cur;
        logic                    in_range;
        logic                    neg;
    } apu_div_tag_t;

endpackage
`default_nettype wire

// ===== hw/rtl/apu_if.sv =====
// Channel interfaces: weight items in, updated weights out, learning rate writes.
`default_nettype none
interface apu_in_if;
    logic                                valid;
    logic                                ready;
    logic [apu_pkg::IDX_W-1:0]           element_index;
    logic signed [apu_pkg::VAL_W-1:0]    current_value;
    logic signed [apu_pkg::VAL_W-1:0]    gradient;

    modport source (output valid, element_index, current_value, gradient, input ready);
    modport sink   (input valid, element_index, current_value, gradient, output ready);
endinterface

interface apu_out_if;
    logic                                valid;
    logic                                ready;
    logic [apu_pkg::IDX_W-1:0]           result_index;
    logic signed [apu_pkg::VAL_W-1:0]    new_value;
    logic                                saturated;

    modport source (output valid, result_index, new_value, saturated, input ready);
    modport sink   (input valid, result_index, new_value, saturated, output ready);
endinterface

interface apu_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [apu_pkg::LR_W-1:0]      learning_rate;

    modport source (output valid, learning_rate, input ready);
    modport sink   (input valid, learning_rate, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/apu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module apu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic                                        re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/apu_sqrt_pipe.sv =====
// Pipelined integer square root of the second moment, one root bit per stage.
`default_nettype none
module apu_sqrt_pipe (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [apu_pkg::V_W-1:0]     in_x,
    input  wire apu_pkg::apu_tag_t           in_tag,
    output logic                             out_valid,
    output logic [apu_pkg::VAL_W-1:0]        out_root,
    output apu_pkg::apu_tag_t                out_tag
);
    import apu_pkg::*;

    logic           vld_reg [SQ_STEPS];
    logic [V_W-1:0] x_reg   [SQ_STEPS];
    logic [V_W-1:0] r_reg   [SQ_STEPS];
    apu_tag_t       tag_reg [SQ_STEPS];

    for (genvar s = 0; s < SQ_STEPS; s++)
    begin : g_step
        localparam logic [V_W-1:0] STEP_BIT = V_W'(1) << (V_W - 2 - 2 * s);

        logic           v_in;
        logic [V_W-1:0] x_in;
        logic [V_W-1:0] r_in;
        apu_tag_t       t_in;
        logic [V_W-1:0] cand;
        logic [V_W-1:0] x_next;
        logic [V_W-1:0] r_next;

        if (s == 0)
        begin : g_first
            assign v_in = in_valid;
            assign x_in = in_x;
            assign r_in = '0;
            assign t_in = in_tag;
        end
        else
        begin : g_rest
            assign v_in = vld_reg[s-1];
            assign x_in = x_reg[s-1];
            assign r_in = r_reg[s-1];
            assign t_in = tag_reg[s-1];
        end

        // Subtract the trial value when it fits, else halve the partial root
        always_comb
        begin
            cand = r_in + STEP_BIT;
            if (x_in >= cand)
            begin
                x_next = x_in - cand;
                r_next = (r_in >> 1) + STEP_BIT;
            end
            else
            begin
                x_next = x_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s]   <= x_next;
                r_reg[s]   <= r_next;
                tag_reg[s] <= t_in;
            end
        end
    end

    assign out_valid = vld_reg[SQ_STEPS-1];
    assign out_root  = r_reg[SQ_STEPS-1][VAL_W-1:0];
    assign out_tag   = tag_reg[SQ_STEPS-1];
endmodule
`default_nettype wire

// ===== hw/rtl/apu_div_pipe.sv =====
// Pipelined rounded division of |lr*m| by the shifted root, one quotient bit per stage.
`default_nettype none
module apu_div_pipe (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [apu_pkg::NUM_W-1:0]     in_mag,
    input  wire logic [apu_pkg::DEN_W-1:0]     in_den,
    input  wire apu_pkg::apu_div_tag_t         in_tag,
    output logic                               out_valid,
    output logic [apu_pkg::Q_W-1:0]            out_quot,
    output apu_pkg::apu_div_tag_t              out_tag
);
    import apu_pkg::*;

    logic             vld_reg [DIV_STEPS+1];
    logic [NUM_W-1:0] dvd_reg [DIV_STEPS+1];
    logic [DEN_W-1:0] den_reg [DIV_STEPS+1];
    logic [DEN_W-1:0] rem_reg [DIV_STEPS+1];
    logic [Q_W-1:0]   q_reg   [DIV_STEPS+1];
    apu_div_tag_t     tag_reg [DIV_STEPS+1];

    logic [NUM_W-1:0] dividend;

    // Add half the divisor for round-to-nearest
    assign dividend = in_mag + NUM_W'(in_den >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    // Top dividend bits lie below the divisor, so start the remainder with them
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvd_reg[0] <= dividend;
            den_reg[0] <= in_den;
            rem_reg[0] <= DEN_W'(dividend[NUM_W-1:Q_W]);
            q_reg[0]   <= '0;
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar s = 1; s <= DIV_STEPS; s++)
    begin : g_step
        logic [DEN_W:0]   rem2;
        logic [DEN_W-1:0] rem_next;
        logic             q_bit;

        always_comb
        begin
            rem2 = {rem_reg[s-1], dvd_reg[s-1][Q_W-s]};
            if (rem2 >= {1'b0, den_reg[s-1]})
            begin
                rem_next = DEN_W'(rem2 - {1'b0, den_reg[s-1]});
                q_bit    = 1'b1;
            end
            else
            begin
                rem_next = rem2[DEN_W-1:0];
                q_bit    = 1'b0;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dvd_reg[s] <= dvd_reg[s-1];
                den_reg[s] <= den_reg[s-1];
                rem_reg[s] <= rem_next;
                q_reg[s]   <= {q_reg[s-1][Q_W-2:0], q_bit};
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS];
    assign out_quot  = q_reg[DIV_STEPS];
    assign out_tag   = tag_reg[DIV_STEPS];
endmodule
`default_nettype wire

// ===== hw/rtl/adam_parameter_update.sv =====
// Top level of the Adam parameter update engine (no bias correction), fixed point.
// Usage:
//   items   : one transaction per weight element (index, Q16.16 value, Q16.16 gradient).
//   results : one transaction per item, in order (index, updated value, saturation flag).
//   cfg     : writes the Q0.24 learning rate; always ready, write only while idle.
// The first and second moments live in one RAM of ELEMENT_COUNT entries. After reset
// a clearing pass zeroes the RAM, one entry per cycle; items.ready stays low until it
// ends. Configuration writes are taken during the pass as ever.
// Throughput: one item per cycle while the skid register is free, including runs on the
// same element; the moment update is a read-modify-write with a one-entry bypass.
// Path: an accepted item passes the input stage, moment update, 32 square root stages,
// the learning rate multiply, 49 divider stages and the output register; the first of
// these 85 registers loads at the accepting edge. Most of these registers lie in the
// square root and division pipelines.
// When results.ready is low with a result waiting, the next result to arrive drops into
// a one-entry skid register; once that is full the whole pipeline holds and items.ready
// drops; nothing is lost or repeated. items.ready comes from registered state only, so
// the skid register parts the two sides.
`default_nettype none
module adam_parameter_update (
    input  wire logic   clk,
    input  wire logic   rst_n,
    apu_in_if.sink      items,
    apu_out_if.source   results,
    apu_cfg_if.sink     cfg
);
    import apu_pkg::*;

    // Clearing sequencer
    apu_state_t        state_reg;
    apu_state_t        state_next;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              clearing;

    // Pipeline control
    logic advance;
    logic in_accept;

    logic [LR_W-1:0] lr_reg;

    // Input stage
    logic                    a_valid_reg;
    logic [IDX_W-1:0]        a_idx_reg;
    logic signed [VAL_W-1:0] a_cur_reg;
    logic signed [VAL_W-1:0] a_g_reg;
    logic [V_W-1:0]          a_g2_reg;
    logic                    a_in_range_reg;
    logic [VAL_W-1:0]        g_mag;

    // Moment RAM and bypass
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [VAL_W+V_W-1:0]    ram_wdata;
    logic [VAL_W+V_W-1:0]    ram_rdata;
    logic                    byp_valid_reg;
    logic [ADDR_W-1:0]       byp_idx_reg;
    logic signed [VAL_W-1:0] byp_m_reg;
    logic [V_W-1:0]          byp_v_reg;
    logic signed [VAL_W-1:0] m_old;
    logic [V_W-1:0]          v_old;
    logic signed [49:0]      m_sum;
    logic [80:0]             v_sum;
    logic signed [VAL_W-1:0] m_next;
    logic [V_W-1:0]          v_next;

    // Update stage
    logic           b_valid_reg;
    apu_tag_t       b_tag_reg;
    logic [V_W-1:0] b_v_reg;

    // Square root outputs
    logic             sq_valid;
    logic [VAL_W-1:0] sq_root;
    apu_tag_t         sq_tag;

    // Multiply stage
    logic signed [56:0] num;
    logic               mp_valid_reg;
    logic [NUM_W-1:0]   mp_mag_reg;
    logic [DEN_W-1:0]   mp_den_reg;
    apu_div_tag_t       mp_tag_reg;

    // Divider outputs
    logic         dv_valid;
    logic [Q_W-1:0] dv_quot;
    apu_div_tag_t dv_tag;

    // Output stage
    logic signed [49:0]      delta;
    logic signed [49:0]      res_wide;
    logic signed [VAL_W-1:0] res_val;
    logic                    res_sat;
    logic                    out_valid_reg;
    logic [IDX_W-1:0]        out_idx_reg;
    logic signed [VAL_W-1:0] out_val_reg;
    logic                    out_sat_reg;
    logic                    skid_valid_reg;
    logic [IDX_W-1:0]        skid_idx_reg;
    logic signed [VAL_W-1:0] skid_val_reg;
    logic                    skid_sat_reg;

    //------------------------------------------------------------------
    // Clearing sequencer: sweep the moment RAM to zero after reset
    //------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(ELEMENT_COUNT - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_CLEAR: clearing = 1'b1;
            ST_RUN:   clearing = 1'b0;
            default:  clearing = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    //------------------------------------------------------------------
    // Handshakes: advance the whole pipeline while the skid register is free
    //------------------------------------------------------------------
    assign advance     = !skid_valid_reg;
    assign items.ready = advance && !clearing;
    assign in_accept   = items.valid && items.ready;
    assign cfg.ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg <= LR_RESET;
        end
        else if (cfg.valid)
        begin
            lr_reg <= cfg.learning_rate;
        end
    end

    //------------------------------------------------------------------
    // Input stage: square the gradient, issue the moment read
    //------------------------------------------------------------------
    assign g_mag = items.gradient[VAL_W-1] ? VAL_W'(-items.gradient) : items.gradient;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_idx_reg      <= items.element_index;
            a_cur_reg      <= items.current_value;
            a_g_reg        <= items.gradient;
            a_g2_reg       <= V_W'(g_mag) * V_W'(g_mag);
            a_in_range_reg <= (32'(items.element_index) < ELEMENT_COUNT);
        end
    end

    apu_ram #(
        .WIDTH (VAL_W + V_W),
        .DEPTH (ELEMENT_COUNT)
    ) u_moment_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (items.element_index[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    //------------------------------------------------------------------
    // Moment update: read-modify-write; new moments are computed and written in the same cycle
    //------------------------------------------------------------------
    // The previous item's write may land at the same edge as this item's read; take it
    // from the bypass instead.
    always_comb
    begin
        if (byp_valid_reg && (byp_idx_reg == a_idx_reg[ADDR_W-1:0]))
        begin
            m_old = byp_m_reg;
            v_old = byp_v_reg;
        end
        else
        begin
            m_old = ram_rdata[VAL_W+V_W-1:V_W];
            v_old = ram_rdata[V_W-1:0];
        end
        m_sum  = 50'(m_old) * B1_Q16 + 50'(a_g_reg) * B1C_Q16 + 50'sd32768;
        v_sum  = 81'(v_old) * B2_Q16 + 81'(a_g2_reg) * B2C_Q16 + 81'd32768;
        m_next = m_sum[47:16];
        v_next = v_sum[79:16];
    end

    always_comb
    begin
        if (clearing)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = advance && a_valid_reg && a_in_range_reg;
            ram_waddr = a_idx_reg[ADDR_W-1:0];
            ram_wdata = {m_next, v_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
        end
        else if (clearing)
        begin
            byp_valid_reg <= 1'b0;
        end
        else if (ram_we)
        begin
            byp_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!clearing && ram_we)
        begin
            byp_idx_reg <= ram_waddr;
            byp_m_reg   <= m_next;
            byp_v_reg   <= v_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_tag_reg.idx      <= a_idx_reg;
            b_tag_reg.cur      <= a_cur_reg;
            b_tag_reg.m        <= m_next;
            b_tag_reg.in_range <= a_in_range_reg;
            b_v_reg            <= v_next;
        end
    end

    //------------------------------------------------------------------
    // Square root of the new second moment
    //------------------------------------------------------------------
    apu_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (b_valid_reg),
        .in_x      (b_v_reg),
        .in_tag    (b_tag_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    //------------------------------------------------------------------
    // Multiply stage: lr * m, divisor (root + eps) in Q16.16 shifted by 8
    //------------------------------------------------------------------
    assign num = 57'(signed'({1'b0, lr_reg})) * 57'(sq_tag.m);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            mp_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mp_mag_reg          <= num[56] ? NUM_W'(-num) : num[NUM_W-1:0];
            mp_den_reg          <= {(VAL_W + 1)'(sq_root) + 1'b1, 8'd0};
            mp_tag_reg.idx      <= sq_tag.idx;
            mp_tag_reg.cur      <= sq_tag.cur;
            mp_tag_reg.in_range <= sq_tag.in_range;
            mp_tag_reg.neg      <= num[56];
        end
    end

    apu_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (mp_valid_reg),
        .in_mag    (mp_mag_reg),
        .in_den    (mp_den_reg),
        .in_tag    (mp_tag_reg),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_tag   (dv_tag)
    );

    //------------------------------------------------------------------
    // Output stage: subtract the step (none for an out-of-range index), saturate, hold until taken
    //------------------------------------------------------------------
    always_comb
    begin
        delta    = dv_tag.neg ? -50'(signed'({2'b00, dv_quot})) : 50'(signed'({2'b00, dv_quot}));
        res_wide = 50'(dv_tag.cur) - delta;
        if (!dv_tag.in_range)
        begin
            res_val = dv_tag.cur;
            res_sat = 1'b0;
        end
        else if (res_wide > 50'sd2147483647)
        begin
            res_val = 32'sh7FFFFFFF;
            res_sat = 1'b1;
        end
        else if (res_wide < -50'sd2147483648)
        begin
            res_val = 32'sh80000000;
            res_sat = 1'b1;
        end
        else
        begin
            res_val = res_wide[VAL_W-1:0];
            res_sat = 1'b0;
        end
    end

    // Park an arriving result in the skid register while the presented one waits;
    // refill the result register from it once the waiting one is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (!out_valid_reg || results.ready)
            begin
                out_valid_reg <= dv_valid;
            end
            else if (dv_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (results.ready)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (!out_valid_reg || results.ready)
            begin
                out_idx_reg <= dv_tag.idx;
                out_val_reg <= res_val;
                out_sat_reg <= res_sat;
            end
            else
            begin
                skid_idx_reg <= dv_tag.idx;
                skid_val_reg <= res_val;
                skid_sat_reg <= res_sat;
            end
        end
        else if (results.ready)
        begin
            out_idx_reg <= skid_idx_reg;
            out_val_reg <= skid_val_reg;
            out_sat_reg <= skid_sat_reg;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.result_index = out_idx_reg;
    assign results.new_value    = out_val_reg;
    assign results.saturated    = out_sat_reg;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !items.ready)
        else $error("item ready during clearing pass");

    a_sat_is_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.saturated) |->
        ((results.new_value == 32'sh7FFFFFFF) || (results.new_value == 32'sh80000000)))
        else $error("saturated flag without a clipped value");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> a_valid_reg)
        else $error("accepted item missing from input stage");

    a_bypass_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && ram_we) |=>
        (byp_valid_reg && (byp_idx_reg == $past(ram_waddr))))
        else $error("bypass does not hold the last moment write");

    a_skid_behind_result: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full with no result presented");

endmodule
`default_nettype wire

// ===== dv/apu_tb_scoreboard.sv =====
// Scoreboard class: predicts updated weights and checks them against the block's results.
class apu_update_board;
    logic signed [31:0] m_store [0:apu_pkg::ELEMENT_COUNT-1];
    logic [63:0]        v_store [0:apu_pkg::ELEMENT_COUNT-1];
    logic [23:0]        lr;
    logic [11:0]        exp_idx [$];
    logic [31:0]        exp_val [$];
    logic               exp_sat [$];
    int                 errors;

    function new();
        for (int i = 0; i < apu_pkg::ELEMENT_COUNT; i++)
        begin
            m_store[i] = 0;
            v_store[i] = 0;
        end
        lr = apu_pkg::LR_RESET;
        errors = 0;
    endfunction

    // integer square root, floor
    function logic [63:0] root64(logic [127:0] x);
        logic [127:0] r;
        logic [127:0] b;
        r = 0;
        b = 128'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r[63:0];
    endfunction

    // note an accepted item: update moments and push the expected result
    function void note_item(logic [11:0] idx, logic signed [31:0] cur, logic signed [31:0] g);
        logic signed [127:0] s, m, num, delta, res;
        logic [127:0] gm, v, d, den, mag, q;
        logic sat;
        res = cur;
        sat = 0;
        if (idx < apu_pkg::ELEMENT_COUNT)
        begin
            s = 128'sd58982 * m_store[idx] + 128'sd6554 * g + 128'sd32768;
            m = s >>> 16;
            gm = (g < 0) ? -g : g;
            v = (128'd64881 * v_store[idx] + 128'd655 * (gm * gm) + 128'd32768) >> 16;
            m_store[idx] = m[31:0];
            v_store[idx] = v[63:0];
            d = {64'd0, root64(v)} + 1;
            den = d << 8;
            num = $signed({104'd0, lr}) * m;
            mag = (num < 0) ? -num : num;
            q = (mag + (den >> 1)) / den;
            delta = (num < 0) ? -$signed(q) : $signed(q);
            res = cur - delta;
            if (res > 128'sh7FFFFFFF)
            begin
                res = 128'sh7FFFFFFF;
                sat = 1;
            end
            else if (res < -128'sh80000000)
            begin
                res = -128'sh80000000;
                sat = 1;
            end
        end
        exp_idx.push_back(idx);
        exp_val.push_back(res[31:0]);
        exp_sat.push_back(sat);
    endfunction

    function void check_result(logic [11:0] idx, logic [31:0] val, logic sat);
        logic [11:0] ei;
        logic [31:0] ev;
        logic es;
        if (exp_idx.size() == 0)
        begin
            $display("%0t: unexpected result idx %0d value %h", $time, idx, val);
            errors++;
            return;
        end
        ei = exp_idx.pop_front();
        ev = exp_val.pop_front();
        es = exp_sat.pop_front();
        if (ei !== idx)
        begin
            $display("%0t: result_index expected %0d actual %0d", $time, ei, idx);
            errors++;
        end
        if (ev !== val)
        begin
            $display("%0t: new_value expected %h actual %h", $time, ev, val);
            errors++;
        end
        if (es !== sat)
        begin
            $display("%0t: saturated expected %0d actual %0d", $time, es, sat);
            errors++;
        end
    endfunction

    function int pending();
        return exp_idx.size();
    endfunction
endclass

// ===== dv/tb.sv =====
// Testbench top: drives weight items and learning rate writes, checks updated weights.
module tb;
    import apu_pkg::*;

    localparam int LATENCY = 84;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 0;
    logic rst_n = 0;

    apu_in_if  items();
    apu_out_if results();
    apu_cfg_if cfg();

    adam_parameter_update u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .cfg     (cfg)
    );

    apu_update_board board = new();

    // idle control: percent chance of idling per cycle on each side
    int  send_idle_pct = 21;
    int  recv_idle_pct = 21;
    bit  recv_hold = 0;
    int  idle_cycles = 0;
    bit  timed_out = 0;

    always #6 clk = ~clk;

    initial
    begin
        items.valid = 0;
        items.element_index = 0;
        items.current_value = 0;
        items.gradient = 0;
        results.ready = 0;
        cfg.valid = 0;
        cfg.learning_rate = 0;
    end

    // check every result transaction at the accepting edge
    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready)
            board.check_result(results.result_index, results.new_value, results.saturated);
    end

    // receiver: random stalls, or a held-off stretch when requested
    always @(posedge clk)
    begin
        if (!rst_n)
            results.ready <= 0;
        else
            results.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: count cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((items.valid && items.ready) || (results.valid && results.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("Test completed with failures");
            $finish;
        end
    end

    // offer one item and hold it until accepted; valid stays high for the next item
    task automatic send_item(logic [11:0] idx, logic [31:0] cur, logic [31:0] g);
        while ($urandom_range(99) < send_idle_pct)
        begin
            items.valid <= 0;
            @(posedge clk);
        end
        items.valid <= 1;
        items.element_index <= idx;
        items.current_value <= cur;
        items.gradient <= g;
        @(posedge clk);
        while (!items.ready)
            @(posedge clk);
        board.note_item(idx, cur, g);
    endtask

    // write the learning rate; only called while idle
    task automatic write_rate(logic [23:0] rate);
        cfg.valid <= 1;
        cfg.learning_rate <= rate;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        board.lr = rate;
        cfg.valid <= 0;
        @(posedge clk);
    endtask

    // drop valid, hold until every expected result has come, then let the pipeline drain
    task automatic drain();
        items.valid <= 0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(255) - 128;
            3: return $signed($urandom_range(2000000)) - 1000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [23:0] pick_rate(int k);
        case (k % 5)
            0: return 24'hFFFFFF;
            1: return 24'd0;
            2: return 24'd16777;
            3: return 24'h800000;
            default: return 24'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [11:0] hot;
        repeat (11) @(posedge clk);
        rst_n <= 1;

        // directed: field extremes, repeated elements, saturation both ways
        write_rate(24'hFFFFFF);
        send_item(12'd0, 32'h00000000, 32'h00000000);
        send_item(12'd4095, 32'h7FFFFFFF, 32'h80000000);
        send_item(12'd4095, 32'h7FFFFFFF, 32'h80000000);
        send_item(12'd1, 32'h80000000, 32'h7FFFFFFF);
        send_item(12'd1, 32'h80000000, 32'h7FFFFFFF);
        send_item(12'd2, 32'h00010000, 32'h00000001);
        send_item(12'd2, 32'h00010000, 32'hFFFFFFFF);
        send_item(12'd3, 32'hFFFFFFFF, 32'h00010000);
        send_item(12'd3, 32'hFFFFFFFF, 32'hFFFF0000);
        send_item(12'd2048, 32'h12345678, 32'hEDCBA987);
        send_item(12'd2048, 32'h55555555, 32'hAAAAAAAA);
        drain();
        write_rate(24'd0);
        send_item(12'd4095, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_item(12'd0, 32'h80000000, 32'h80000000);
        drain();

        // random phases, each opening with a learning rate write; one phase without idling
        for (int ph = 0; ph < 8; ph++)
        begin
            write_rate(pick_rate(ph));
            send_idle_pct = (ph == 3) ? 0 : 21;
            recv_idle_pct = (ph == 3) ? 0 : 21;
            hot = 12'($urandom);
            for (int n = 0; n < 165; n++)
            begin
                // hold off the receiver while items keep coming to fill the pipeline
                if (ph == 5 && n == 10)
                    fork
                        begin
                            recv_hold = 1;
                            repeat (400) @(posedge clk);
                            recv_hold = 0;
                        end
                    join_none
                if ($urandom_range(3) == 0)
                    send_item(hot + 12'($urandom_range(3)), rand_word(), rand_word());
                else
                    send_item(12'($urandom), rand_word(), rand_word());
            end
            // pause the sender until every expected result has come
            drain();
        end
        send_idle_pct = 21;
        recv_idle_pct = 21;
        write_rate(24'd16777);
        for (int n = 0; n < 30; n++)
            send_item(12'($urandom), rand_word(), rand_word());
        drain();

        if (board.errors == 0 && board.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/apu_pkg.sv
hw/rtl/apu_if.sv
hw/rtl/apu_ram.sv
hw/rtl/apu_sqrt_pipe.sv
hw/rtl/apu_div_pipe.sv
hw/rtl/adam_parameter_update.sv
dv/apu_tb_scoreboard.sv
dv/tb.sv
